// ----- hw/rtl/sssp_pkg.sv -----
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared widths and constants for the shortest path block.
// ----------------------------------------------------------------------------
package sssp_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;
  localparam int VBits       = 6;
  localparam int EBits       = 10;
  localparam int CountBits   = 11;
  localparam int WBits       = 16;
  localparam int DBits       = 22;
  localparam int CfgBits     = 7;

  localparam logic CFG_NUM_VERTICES = 1'b0;
  localparam logic CFG_START_VERTEX = 1'b1;

  typedef logic signed [DBits-1:0] dist_t;
  typedef logic [VBits-1:0] vtx_t;
endpackage

// ----- hw/rtl/single_source_shortest_path_edges.sv -----
// ----------------------------------------------------------------------------
// single_source_shortest_path_edges
// Loads a directed edge list and runs Bellman-Ford from a start vertex.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// item      in         start & !busy         has_edge, edge_source, edge_dest,
//                                            edge_weight, last_edge
// result    out        result_valid strobe   vertex .. last_result
// config    in         cfg_we                cfg_index, cfg_data
//
// The item marked last_edge starts a run: an init state, then passes over the
// edge memory with one shared relax unit that steps each stored edge through
// edge read, vertex read, and compare and write, and a state that closes each
// pass, for up to num_vertices-1 passes plus a check pass, then a lead step
// and one result per vertex, or a single negative_cycle result.
// Reset clears control state; busy stays high for the whole run.
// Results cannot be stalled; they appear one per cycle.
module single_source_shortest_path_edges (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        has_edge,
  input  logic [5:0]  edge_source,
  input  logic [5:0]  edge_dest,
  input  logic signed [15:0] edge_weight,
  input  logic        last_edge,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        result_valid,
  output logic [5:0]  vertex,
  output logic signed [21:0] distance,
  output logic        reachable,
  output logic [5:0]  predecessor,
  output logic        has_predecessor,
  output logic        negative_cycle,
  output logic        edge_overflow,
  output logic        last_result
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_PASS  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;
  localparam logic [2:0] S_NEG   = 3'd7;

  logic [2:0] state;
  logic [6:0] num_vertices;
  logic [5:0] start_vertex;
  logic [6:0] n_use;

  logic [sssp_pkg::VBits+sssp_pkg::VBits+sssp_pkg::WBits-1:0]
    edge_mem [sssp_pkg::MaxEdges];
  logic [sssp_pkg::CountBits-1:0] edge_count;
  logic overflow_seen;

  sssp_pkg::dist_t dist_mem [sssp_pkg::MaxVertices];
  sssp_pkg::vtx_t  pred_mem [sssp_pkg::MaxVertices];
  logic [sssp_pkg::MaxVertices-1:0] reached;
  logic [sssp_pkg::MaxVertices-1:0] pred_ok;

  logic [sssp_pkg::CountBits-1:0] eidx;
  logic [6:0] pass_cnt;
  logic changed;
  logic checking;
  logic [6:0] out_idx;

  logic [27:0] edge_rd;
  sssp_pkg::vtx_t eu, ev;
  logic signed [sssp_pkg::WBits-1:0] ew;
  sssp_pkg::dist_t du, dv;
  sssp_pkg::vtx_t out_p;

  logic signed [sssp_pkg::DBits:0] sum;
  logic better;
  logic edge_ok;
  sssp_pkg::dist_t sum_sat;

  always_comb begin
    if (num_vertices == 7'd0) n_use = 7'd1;
    else if (num_vertices > 7'(sssp_pkg::MaxVertices)) n_use = 7'(sssp_pkg::MaxVertices);
    else n_use = num_vertices;
  end

  assign busy = (state != S_IDLE);
  assign eu = edge_rd[27:22];
  assign ev = edge_rd[21:16];
  assign ew = edge_rd[15:0];
  assign edge_ok = ({1'b0, eu} < n_use) && ({1'b0, ev} < n_use) && reached[eu];
  assign sum = {du[21], du} + (sssp_pkg::DBits+1)'(ew);
  assign better = edge_ok && (!reached[ev] || sum < $signed({dv[21], dv}));
  always_comb begin
    if (sum > 23'sd2097151) sum_sat = 22'sh1FFFFF;
    else if (sum < -23'sd2097152) sum_sat = 22'sh200000;
    else sum_sat = sum[21:0];
  end

  // Edge memory: one write port for loading, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && has_edge && edge_count < 11'(sssp_pkg::MaxEdges) &&
        {1'b0, edge_source} < n_use && {1'b0, edge_dest} < n_use)
      edge_mem[edge_count[9:0]] <= {edge_source, edge_dest, edge_weight};
    edge_rd <= edge_mem[eidx[9:0]];
  end

  // Vertex memories: registered reads at the edge endpoints or the output index.
  always_ff @(posedge clk) begin
    du <= dist_mem[(state == S_OUT) ? out_idx[5:0] : eu];
    dv <= dist_mem[ev];
    out_p <= pred_mem[out_idx[5:0]];
    if (state == S_INIT) dist_mem[start_vertex] <= '0;
    else if (state == S_RELAX && better && !checking) begin
      dist_mem[ev] <= sum_sat;
      pred_mem[ev] <= eu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_vertices <= 7'd64;
      start_vertex <= '0;
      edge_count <= '0;
      overflow_seen <= 1'b0;
      reached <= '0;
      pred_ok <= '0;
      eidx <= '0;
      pass_cnt <= '0;
      changed <= 1'b0;
      checking <= 1'b0;
      out_idx <= '0;
      result_valid <= 1'b0;
      vertex <= '0;
      distance <= '0;
      reachable <= 1'b0;
      predecessor <= '0;
      has_predecessor <= 1'b0;
      negative_cycle <= 1'b0;
      edge_overflow <= 1'b0;
      last_result <= 1'b0;
    end else begin
      result_valid <= (state == S_NEG) || (state == S_OUT && out_idx != 7'd0);
      if (cfg_we) begin
        unique case (cfg_index)
          sssp_pkg::CFG_NUM_VERTICES: num_vertices <= cfg_data;
          sssp_pkg::CFG_START_VERTEX: start_vertex <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (has_edge && {1'b0, edge_source} < n_use && {1'b0, edge_dest} < n_use) begin
              if (edge_count < 11'(sssp_pkg::MaxEdges)) edge_count <= edge_count + 1'b1;
              else overflow_seen <= 1'b1;
            end
            if (last_edge) state <= S_INIT;
          end
        end
        S_INIT: begin
          pred_ok <= '0;
          if ({1'b0, start_vertex} < n_use)
            reached <= {{(sssp_pkg::MaxVertices-1){1'b0}}, 1'b1} << start_vertex;
          else
            reached <= '0;
          eidx <= '0;
          pass_cnt <= 7'd1;
          changed <= 1'b0;
          checking <= (n_use == 7'd1);
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (eidx == edge_count) state <= S_PASS;
          else state <= S_READ;
        end
        S_READ: state <= S_RELAX;
        S_RELAX: begin
          eidx <= eidx + 1'b1;
          if (better && checking) state <= S_NEG;
          else state <= S_FETCH;
          if (better && !checking) begin
            reached[ev] <= 1'b1;
            pred_ok[ev] <= 1'b1;
            changed <= 1'b1;
          end
        end
        S_PASS: begin
          eidx <= '0;
          changed <= 1'b0;
          if (checking) begin
            out_idx <= '0;
            state <= S_OUT;
          end else begin
            state <= S_FETCH;
            if (!changed || pass_cnt + 7'd1 >= n_use) checking <= 1'b1;
            else pass_cnt <= pass_cnt + 7'd1;
          end
        end
        S_NEG: begin
          vertex <= '0;
          distance <= '0;
          reachable <= 1'b0;
          predecessor <= '0;
          has_predecessor <= 1'b0;
          negative_cycle <= 1'b1;
          edge_overflow <= overflow_seen;
          last_result <= 1'b1;
          edge_count <= '0;
          overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        S_OUT: begin
          // The index leads the registered read, so each result uses the previous index.
          out_idx <= out_idx + 7'd1;
          if (out_idx != 7'd0) begin
            vertex <= 6'(out_idx - 7'd1);
            distance <= reached[6'(out_idx - 7'd1)] ? du : '0;
            reachable <= reached[6'(out_idx - 7'd1)];
            predecessor <= pred_ok[6'(out_idx - 7'd1)] ? out_p : '0;
            has_predecessor <= pred_ok[6'(out_idx - 7'd1)];
            negative_cycle <= 1'b0;
            edge_overflow <= overflow_seen;
            last_result <= (out_idx == n_use);
            if (out_idx == n_use) begin
              edge_count <= '0;
              overflow_seen <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/sssp_checker.sv -----
// ----------------------------------------------------------------------------
// sssp_checker
// Port-level checks on the shortest path block.
// ----------------------------------------------------------------------------
module sssp_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_valid,
  input logic negative_cycle,
  input logic last_result
);
  // Results before the last one appear during a run.
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |-> busy) else $error("result outside run");
  // A negative cycle result is the last one.
  a_neg_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && negative_cycle |-> last_result) else $error("neg not last");
  // The last result is shown once the block is already idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |-> !busy) else $error("busy at last");
endmodule

bind single_source_shortest_path_edges sssp_checker u_sssp_checker (
  .clk(clk), .rst(rst), .busy(busy), .result_valid(result_valid),
  .negative_cycle(negative_cycle), .last_result(last_result));

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest path block: edge lists are loaded item
// by item, and a local Bellman-Ford predictor queues the per-vertex results
// that each run must return, which are checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  typedef struct {
    sssp_pkg::vtx_t  vtx;
    sssp_pkg::dist_t dist_value;
    logic  reach;
    sssp_pkg::vtx_t  pred;
    logic  has_pred;
    logic  negc;
    logic  ovf;
    logic  last;
  } vertex_result_t;

  logic clk, rst, start, busy;
  logic has_edge, last_edge;
  logic [5:0] edge_source, edge_dest;
  logic signed [15:0] edge_weight;
  logic cfg_we, cfg_index;
  logic [6:0] cfg_data;
  logic result_valid;
  logic [5:0] vertex, predecessor;
  logic signed [21:0] distance;
  logic reachable, has_predecessor, negative_cycle, edge_overflow, last_result;

  single_source_shortest_path_edges uut (.*);

  // Predictor state.
  logic [5:0] edge_tails [sssp_pkg::MaxEdges];
  logic [5:0] edge_heads [sssp_pkg::MaxEdges];
  int edge_weights [sssp_pkg::MaxEdges];
  int stored_edges;
  bit dropped_edges;
  int vertex_dist [sssp_pkg::MaxVertices];
  bit vertex_reached [sssp_pkg::MaxVertices];
  int vertex_pred [sssp_pkg::MaxVertices];
  bit vertex_has_pred [sssp_pkg::MaxVertices];
  int num_vertices_reg, start_vertex_reg;

  vertex_result_t pending_results [$];
  int errors, results_checked, runs_done, negc_runs, items_sent;
  bit gaps_enabled;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("single_source_shortest_path_edges verification failed");
    $finish;
  end

  function automatic int active_vertices();
    if (num_vertices_reg < 1) return 1;
    if (num_vertices_reg > sssp_pkg::MaxVertices) return sssp_pkg::MaxVertices;
    return num_vertices_reg;
  endfunction

  function automatic bit relax_pass(int n, bit do_update);
    bit changed;
    int u, v;
    longint sum;
    changed = 0;
    for (int e = 0; e < stored_edges; e++) begin
      u = edge_tails[e];
      v = edge_heads[e];
      if (u >= n || v >= n || !vertex_reached[u]) continue;
      sum = longint'(vertex_dist[u]) + longint'(edge_weights[e]);
      if (!vertex_reached[v] || sum < longint'(vertex_dist[v])) begin
        if (!do_update) return 1;
        if (sum > 2097151) vertex_dist[v] = 2097151;
        else if (sum < -2097152) vertex_dist[v] = -2097152;
        else vertex_dist[v] = int'(sum);
        vertex_reached[v] = 1;
        vertex_pred[v] = u;
        vertex_has_pred[v] = 1;
        changed = 1;
      end
    end
    return changed;
  endfunction

  function automatic void predict_shortest_paths();
    int n;
    vertex_result_t r;
    n = active_vertices();
    for (int i = 0; i < sssp_pkg::MaxVertices; i++) begin
      vertex_dist[i] = 0;
      vertex_reached[i] = 0;
      vertex_pred[i] = 0;
      vertex_has_pred[i] = 0;
    end
    if (start_vertex_reg < n) vertex_reached[start_vertex_reg] = 1;
    for (int i = 1; i < n; i++)
      if (!relax_pass(n, 1)) break;
    if (relax_pass(n, 0)) begin
      r = '{vtx: 0, dist_value: 0, reach: 0, pred: 0, has_pred: 0, negc: 1,
            ovf: dropped_edges, last: 1};
      pending_results.push_back(r);
      negc_runs++;
    end else begin
      for (int i = 0; i < n; i++) begin
        r.vtx = sssp_pkg::vtx_t'(i);
        r.reach = vertex_reached[i];
        r.dist_value = vertex_reached[i] ? sssp_pkg::dist_t'(vertex_dist[i]) : '0;
        r.has_pred = vertex_has_pred[i];
        r.pred = vertex_has_pred[i] ? sssp_pkg::vtx_t'(vertex_pred[i]) : '0;
        r.negc = 0;
        r.ovf = dropped_edges;
        r.last = (i + 1 == n);
        pending_results.push_back(r);
      end
    end
    stored_edges = 0;
    dropped_edges = 0;
    runs_done++;
  endfunction

  function automatic void load_edge(logic has, logic [5:0] src, logic [5:0] dst,
                                    logic signed [15:0] w, logic last);
    int n;
    n = active_vertices();
    if (has && src < n && dst < n) begin
      if (stored_edges >= sssp_pkg::MaxEdges) begin
        dropped_edges = 1;
      end else begin
        edge_tails[stored_edges] = src;
        edge_heads[stored_edges] = dst;
        edge_weights[stored_edges] = int'(w);
        stored_edges++;
      end
    end
    if (last) predict_shortest_paths();
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item; start stays high when the next item follows directly.
  task automatic send_item(logic has, logic [5:0] src, logic [5:0] dst,
                           logic signed [15:0] w, logic last);
    int gap;
    @(negedge clk);
    start = 1;
    has_edge = has;
    edge_source = src;
    edge_dest = dst;
    edge_weight = w;
    last_edge = last;
    do @(posedge clk); while (busy);
    load_edge(has, src, dst, w, last);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      has_edge = 1'($urandom_range(0, 1));
      last_edge = 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops start first so that a held item is not taken a second time.
  task automatic wait_results_drained();
    @(negedge clk);
    start = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    wait_results_drained();
    @(negedge clk);
    start = 0;
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == sssp_pkg::CFG_NUM_VERTICES) num_vertices_reg = val;
    else start_vertex_reg = val[5:0];
  endtask

  always @(posedge clk) begin
    vertex_result_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result for vertex %0d", $time, vertex);
        errors++;
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (vertex !== e.vtx || distance !== e.dist_value || reachable !== e.reach ||
            predecessor !== e.pred || has_predecessor !== e.has_pred ||
            negative_cycle !== e.negc || edge_overflow !== e.ovf ||
            last_result !== e.last) begin
          $display("%0t: mismatch expected v=%0d d=%0d r=%0b p=%0d hp=%0b nc=%0b ov=%0b l=%0b",
                   $time, e.vtx, e.dist_value, e.reach, e.pred, e.has_pred, e.negc,
                   e.ovf, e.last);
          $display("%0t:          actual v=%0d d=%0d r=%0b p=%0d hp=%0b nc=%0b ov=%0b l=%0b",
                   $time, vertex, distance, reachable, predecessor, has_predecessor,
                   negative_cycle, edge_overflow, last_result);
          errors++;
        end
      end
    end
  end

  // Default registers: extreme weights and endpoints on a full-size graph.
  task automatic test_default_graph();
    send_item(1, 0, 1, 16'sh7fff, 0);
    send_item(1, 0, 63, -16'sd32768, 0);
    send_item(1, 1, 2, 16'sd5, 0);
    send_item(1, 63, 63, 16'sd0, 0);
    send_item(1, 63, 62, 16'sd7, 1);
  endtask

  task automatic test_negative_cycle();
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd3);
    write_reg(sssp_pkg::CFG_START_VERTEX, 7'd0);
    send_item(1, 0, 1, 16'sd4, 0);
    send_item(1, 1, 2, -16'sd3, 0);
    send_item(1, 2, 1, -16'sd2, 1);
  endtask

  task automatic test_vertex_count_limits();
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd0);
    send_item(1, 0, 0, 16'sd9, 0);
    send_item(1, 1, 0, 16'sd1, 1);
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd127);
    write_reg(sssp_pkg::CFG_START_VERTEX, 7'd63);
    send_item(1, 63, 0, -16'sd10, 1);
  endtask

  task automatic test_start_out_of_range();
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd4);
    write_reg(sssp_pkg::CFG_START_VERTEX, 7'd40);
    send_item(1, 0, 1, 16'sd2, 0);
    send_item(0, 6'h3f, 6'h3f, 16'shffff, 1);
  endtask

  // Edges stored under a larger vertex count are skipped once it shrinks.
  task automatic test_endpoint_filter();
    write_reg(sssp_pkg::CFG_START_VERTEX, 7'd0);
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd8);
    send_item(1, 0, 6, 16'sd1, 0);
    send_item(1, 0, 9, 16'sd1, 0);
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd5);
    send_item(0, 0, 1, 16'sd3, 0);
    send_item(1, 0, 2, 16'sd3, 0);
    send_item(1, 2, 7, 16'sd3, 1);
  endtask

  task automatic test_edge_overflow();
    write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'd2);
    write_reg(sssp_pkg::CFG_START_VERTEX, 7'd0);
    gaps_enabled = 0;
    for (int i = 0; i < sssp_pkg::MaxEdges + 2; i++)
      send_item(1, 0, 1, 16'(100 - i), 1'(i == sssp_pkg::MaxEdges + 1));
    gaps_enabled = 1;
    // The next graph must see the overflow flag cleared.
    send_item(1, 0, 1, 16'sd1, 1);
  endtask

  task automatic test_random_graphs();
    int n, m, sv, sent;
    int sources [$];
    logic [5:0] dst;
    logic signed [15:0] w;
    int r;
    sent = 0;
    while (sent < 420) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(1, 12);
        m = $urandom_range(0, 20);
      end else begin
        n = $urandom_range(40, 127);
        m = $urandom_range(20, 70);
      end
      sv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63)
                                        : $urandom_range(0, (n > 64 ? 64 : n) - 1);
      write_reg(sssp_pkg::CFG_NUM_VERTICES, 7'(n));
      write_reg(sssp_pkg::CFG_START_VERTEX, 7'(sv));
      gaps_enabled = ($urandom_range(0, 3) != 0);
      sources.delete();
      for (int i = 0; i < m; i++)
        sources.push_back($urandom_range(0, (n > 64 ? 64 : n) - 1));
      sources.sort();
      foreach (sources[i]) begin
        if ($urandom_range(0, 9) == 0)
          send_item(0, 6'($urandom), 6'($urandom), 16'($urandom), 0);
        dst = ($urandom_range(0, 9) == 0) ? 6'($urandom) :
              6'($urandom_range(0, (n > 64 ? 64 : n) - 1));
        r = $urandom_range(0, 99);
        if (r < 60) w = 16'($urandom_range(0, 200));
        else if (r < 85) w = 16'(int'($urandom_range(0, 220)) - 20);
        else w = 16'($urandom);
        send_item(1, 6'(sources[i]), dst, w,
                  1'((i == m - 1) && $urandom_range(0, 1)));
        sent++;
        if (i == m - 1 && stored_edges == 0 && pending_results.size() != 0) m = -1;
      end
      // Close the graph unless its final edge already did.
      if (m != -1 && !(m > 0 && stored_edges == 0 && runs_done > 0 &&
                       pending_results.size() != 0))
        send_item(0, 6'($urandom), 6'($urandom), 16'($urandom), 1);
      sent++;
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    has_edge = 0;
    edge_source = 0;
    edge_dest = 0;
    edge_weight = 0;
    last_edge = 0;
    cfg_we = 0;
    cfg_index = sssp_pkg::CFG_NUM_VERTICES;
    cfg_data = 0;
    stored_edges = 0;
    dropped_edges = 0;
    num_vertices_reg = 64;
    start_vertex_reg = 0;
    errors = 0;
    gaps_enabled = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_default_graph();
    test_negative_cycle();
    test_vertex_count_limits();
    test_start_out_of_range();
    test_endpoint_filter();
    test_edge_overflow();
    test_random_graphs();
    wait_results_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d items in %0d graph runs, %0d with a negative cycle.",
             items_sent, runs_done, negc_runs);
    $display("Checked %0d vertex results; %0d mismatches.", results_checked, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("single_source_shortest_path_edges verification clean");
    end else begin
      $display("single_source_shortest_path_edges verification failed");
    end
    $finish;
  end
endmodule

// ----- single_source_shortest_path_edges.f -----
hw/rtl/sssp_pkg.sv
hw/rtl/single_source_shortest_path_edges.sv
hw/rtl/sssp_checker.sv
tb/tb.sv
